[rtl/mutf8_pkg.sv]
package mutf8_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned PART_W = 16;
	localparam int unsigned SURR_W = 10;
	localparam int unsigned REM_W  = 2;

	// stream data widths, padded to whole bytes
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	// byte classes
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_TAG   = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_TAG   = 8'hE0;
	localparam logic [7:0] SURR_LEAD   = 8'hED;
	localparam logic [7:0] LOW_SURR_TAG = 8'hB0;

	// surrogate range and supplementary base
	localparam logic [PART_W-1:0] HIGH_SURR_MIN = 16'hD800;
	localparam logic [PART_W-1:0] HIGH_SURR_MAX = 16'hDBFF;
	localparam logic [CP_W-1:0]   SUPP_BASE     = 21'h10000;
	localparam logic [CP_W-1:0]   CP_MAX        = 21'h10FFFF;

	// bytes still expected in the current form
	localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
	localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
	localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
	localparam logic [REM_W-1:0] REM_THREE = 2'd3;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            decode_error;
		logic            string_end;
	} result_t;

	typedef struct packed {
		logic [PART_W-1:0] partial;
		logic [REM_W-1:0]  remaining;
		logic [SURR_W-1:0] high_bits;
		logic              surr_pending;
		logic              dropping;
	} dec_state_t;

endpackage

[rtl/modified_utf8_decoder.sv]
// channel   dir  tdata                    tuser          tlast
// s_*       in   [7:0] byte_in            -              end_of_string
// m_*       out  [20:0] code_point        decode_error   string_end
//
// one byte per cycle sustained unless the output stalls; on its way to a result a
// byte passes the input register, then the decode step into the result register
// arst_n clears the decode state and both valid flags; decoding starts fresh
// a byte that gives no result retires even while the result register is full
// s_tready falls only when a result-producing byte waits behind a stalled output
module modified_utf8_decoder
	import mutf8_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] byte_in
	input  logic                   s_tlast,   // end_of_string
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic                   m_tuser,   // [0] decode_error
	output logic                   m_tlast    // string_end
);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eos_s1;

	// decode state and result register
	dec_state_t st_q, st_next;
	logic       out_valid_q;
	result_t    out_q, res;

	logic have_res;   // this byte gives a result
	logic advance;    // byte in the input register retires this cycle
	logic bad, have;
	logic [CP_W-1:0]   cp;
	logic [PART_W-1:0] shifted;

	assign shifted = {st_q.partial[PART_W-7:0], byte_s1[5:0]};

	// decode step
	always_comb begin
		st_next = st_q;
		bad     = 1'b0;
		have    = 1'b0;
		cp      = '0;
		if (st_q.dropping) begin
			if (eos_s1) begin
				st_next = '0;
			end
		end else if (st_q.surr_pending) begin
			unique case (st_q.remaining)
				REM_THREE: begin
					if (byte_s1 == SURR_LEAD) st_next.remaining = REM_TWO;
					else bad = 1'b1;
				end
				REM_TWO: begin
					if ((byte_s1 & LEAD3_MASK) == LOW_SURR_TAG) begin
						st_next.partial   = {12'd0, byte_s1[3:0]};
						st_next.remaining = REM_ONE;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					if ((byte_s1 & CONT_MASK) == CONT_TAG) begin
						// low surrogate payload is four bits plus six bits
						cp = SUPP_BASE + {1'b0, st_q.high_bits, 10'd0}
							+ {11'd0, st_q.partial[3:0], byte_s1[5:0]};
						have    = 1'b1;
						st_next = '0;
					end else begin
						bad = 1'b1;
					end
				end
			endcase
		end else if (st_q.remaining != REM_NONE) begin
			if ((byte_s1 & CONT_MASK) == CONT_TAG) begin
				st_next.partial   = shifted;
				st_next.remaining = st_q.remaining - REM_ONE;
				if (st_q.remaining == REM_ONE) begin
					if (shifted >= HIGH_SURR_MIN && shifted <= HIGH_SURR_MAX) begin
						// high surrogate: wait for the low-surrogate form
						st_next.high_bits    = shifted[SURR_W-1:0];
						st_next.surr_pending = 1'b1;
						st_next.remaining    = REM_THREE;
						st_next.partial      = '0;
					end else begin
						cp      = {5'd0, shifted};
						have    = 1'b1;
						st_next = '0;
					end
				end
			end else begin
				bad = 1'b1;
			end
		end else begin
			priority if (!byte_s1[7]) begin
				cp   = {13'd0, byte_s1};
				have = 1'b1;
			end else if ((byte_s1 & LEAD2_MASK) == LEAD2_TAG) begin
				st_next.partial   = {11'd0, byte_s1[4:0]};
				st_next.remaining = REM_ONE;
			end else if ((byte_s1 & LEAD3_MASK) == LEAD3_TAG) begin
				st_next.partial   = {12'd0, byte_s1[3:0]};
				st_next.remaining = REM_TWO;
			end else begin
				bad = 1'b1;
			end
		end

		// error, truncation and end-of-string handling
		res      = '0;
		have_res = 1'b0;
		if (bad) begin
			st_next          = '0;
			st_next.dropping = !eos_s1;
			res.decode_error = 1'b1;
			res.string_end   = eos_s1;
			have_res         = 1'b1;
		end else if (have) begin
			res.code_point = cp;
			res.string_end = eos_s1;
			have_res       = 1'b1;
		end else if (eos_s1 && !st_q.dropping) begin
			// string ends inside a form or a pair
			st_next          = '0;
			res.decode_error = 1'b1;
			res.string_end   = 1'b1;
			have_res         = 1'b1;
		end
	end

	assign advance  = valid_s1 && (!have_res || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
			eos_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_next;
			end
			if (advance && have_res) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && have_res) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, out_q.code_point};
	assign m_tuser  = out_q.decode_error;
	assign m_tlast  = out_q.string_end;

	// an error result carries no code point
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[CP_W-1:0] == '0)
		else $error("error result with nonzero code point");

	// decoded values stay inside the unicode range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CP_W-1:0] <= CP_MAX)
		else $error("code point out of range");

	// dropping mode holds no partial sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.dropping |-> !st_q.surr_pending && st_q.remaining == REM_NONE)
		else $error("dropping with a sequence open");

	// a pending high surrogate always expects more bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.surr_pending |-> st_q.remaining != REM_NONE)
		else $error("surrogate pending with nothing expected");

	// a retired final byte always leaves the start state
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |=> st_q == '0)
		else $error("state not cleared after end of string");

endmodule

[sim/tb_modified_utf8_decoder.sv]
`timescale 1ns / 1ps

module tb_modified_utf8_decoder;
	import mutf8_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1800;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned NUM_ROWS     = 26;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              last;
		logic              typed;
		logic [CP_W-1:0]   cp;
		logic              err;
	} stim_row_t;

	typedef enum int {
		CH_ASCII, CH_TWO, CH_THREE, CH_PAIR, CH_LONE_LOW, CH_LONE_HIGH, CH_JUNK
	} char_kind_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	// decoder state mirrored by the predictor
	logic [PART_W-1:0] dec_partial   = '0;
	logic [REM_W-1:0]  dec_remaining = REM_NONE;
	logic [SURR_W-1:0] dec_high      = '0;
	logic              dec_surr      = 1'b0;
	logic              dec_drop      = 1'b0;

	result_t           code_points_due[$];
	logic [BYTE_W-1:0] string_bytes[$];
	int unsigned       mismatches  = 0;
	int unsigned       cycle_count = 0;
	int unsigned       live_bytes  = 0;
	int unsigned       send_idle   = 12;
	int unsigned       recv_idle   = 65;

	stim_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
		'{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 21'h000000, 1'b1},  // bad lead byte on the final byte
		'{8'hC0, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'h80, 1'b0, 1'b1, 21'h000000, 1'b0},  // overlong zero
		'{8'hEF, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 21'h00FFFF, 1'b0},
		'{8'hED, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hAF, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hED, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hBF, 1'b1, 1'b1, 21'h10FFFF, 1'b0},  // largest supplementary value
		'{8'hED, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hB0, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'h80, 1'b0, 1'b1, 21'h00DC00, 1'b0},  // low surrogate with no high half
		'{8'hED, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'hA0, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'h41, 1'b0, 1'b1, 21'h000000, 1'b1},  // high surrogate not followed by ED
		'{8'h42, 1'b1, 1'b0, 21'h000000, 1'b0},  // dropped, closes the string
		'{8'hDF, 1'b0, 1'b0, 21'h000000, 1'b0},
		'{8'h7F, 1'b0, 1'b1, 21'h000000, 1'b1},  // bad continuation
		'{8'h80, 1'b1, 1'b0, 21'h000000, 1'b0},
		'{8'hE4, 1'b1, 1'b1, 21'h000000, 1'b1}   // string ends inside a form
	};

	modified_utf8_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_form();
		dec_partial   = '0;
		dec_remaining = REM_NONE;
		dec_high      = '0;
		dec_surr      = 1'b0;
	endfunction

	// advances the mirrored state by one byte; returns 1 when a result (code point or error) comes out
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic last,
			output result_t res);
		bit              bad;
		bit              got;
		logic [CP_W-1:0] cp;
		bad = 1'b0;
		got = 1'b0;
		cp  = '0;
		res = '0;
		if (dec_drop) begin
			if (last) begin
				dec_drop = 1'b0;
				clear_form();
			end
			return 1'b0;
		end
		if (dec_surr) begin
			if (dec_remaining == REM_THREE) begin
				if (b == SURR_LEAD) dec_remaining = REM_TWO;
				else bad = 1'b1;
			end else if (dec_remaining == REM_TWO) begin
				if ((b & LEAD3_MASK) == LOW_SURR_TAG) begin
					dec_partial   = {12'h000, b[3:0]};
					dec_remaining = REM_ONE;
				end else begin
					bad = 1'b1;
				end
			end else if ((b & CONT_MASK) == CONT_TAG) begin
				dec_partial = {dec_partial[9:0], b[5:0]};
				cp  = SUPP_BASE + {1'b0, dec_high, 10'h000} + {11'h000, dec_partial[9:0]};
				got = 1'b1;
				clear_form();
			end else begin
				bad = 1'b1;
			end
		end else if (dec_remaining != REM_NONE) begin
			if ((b & CONT_MASK) == CONT_TAG) begin
				dec_partial   = {dec_partial[9:0], b[5:0]};
				dec_remaining = dec_remaining - 1'b1;
				if (dec_remaining == REM_NONE) begin
					if (dec_partial >= HIGH_SURR_MIN && dec_partial <= HIGH_SURR_MAX) begin
						dec_high      = dec_partial[9:0];
						dec_surr      = 1'b1;
						dec_remaining = REM_THREE;
						dec_partial   = '0;
					end else begin
						cp  = {5'h00, dec_partial};
						got = 1'b1;
						clear_form();
					end
				end
			end else begin
				bad = 1'b1;
			end
		end else if (!b[7]) begin
			cp  = {13'h0000, b};
			got = 1'b1;
		end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
			dec_partial   = {11'h000, b[4:0]};
			dec_remaining = REM_ONE;
		end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
			dec_partial   = {12'h000, b[3:0]};
			dec_remaining = REM_TWO;
		end else begin
			bad = 1'b1;
		end

		if (bad) begin
			clear_form();
			dec_drop = !last;
			res = '{code_point: '0, decode_error: 1'b1, string_end: last};
			return 1'b1;
		end
		if (got) begin
			res = '{code_point: cp, decode_error: 1'b0, string_end: last};
			return 1'b1;
		end
		if (last) begin
			clear_form();
			res = '{code_point: '0, decode_error: 1'b1, string_end: 1'b1};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		$display("mismatch on %s: expected %h, got %h (cycle %0d)", what, want, seen,
			cycle_count);
		mismatches++;
	endtask

	// drives one byte, waits for its transfer, then records what it should produce
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
			input logic typed, input result_t typed_res);
		result_t res;
		bit      got;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (!dec_drop) live_bytes++;
		got = decode_byte(b, last, res);
		if (typed) code_points_due.insert(code_points_due.size(), typed_res);
		else if (got) code_points_due.insert(code_points_due.size(), res);
	endtask

	function automatic void add_byte(input logic [BYTE_W-1:0] b);
		string_bytes.insert(string_bytes.size(), b);
	endfunction

	function automatic void push_form2(input logic [10:0] v);
		add_byte(LEAD2_TAG | {3'b000, v[10:6]});
		add_byte(CONT_TAG | {2'b00, v[5:0]});
	endfunction

	function automatic void push_form3(input logic [15:0] v);
		add_byte(LEAD3_TAG | {4'h0, v[15:12]});
		add_byte(CONT_TAG | {2'b00, v[11:6]});
		add_byte(CONT_TAG | {2'b00, v[5:0]});
	endfunction

	// mostly well-formed strings with random content, some corrupted or cut short
	function automatic void build_string();
		int unsigned n_chars;
		int unsigned pick;
		int unsigned cut;
		char_kind_t  kind;
		logic [15:0] v;
		logic [19:0] supp;
		string_bytes.delete();
		n_chars = $urandom_range(8, 1);
		for (int unsigned i = 0; i < n_chars; i++) begin
			pick = $urandom_range(99);
			if (pick < 30)      kind = CH_ASCII;
			else if (pick < 48) kind = CH_TWO;
			else if (pick < 66) kind = CH_THREE;
			else if (pick < 84) kind = CH_PAIR;
			else if (pick < 89) kind = CH_LONE_LOW;
			else if (pick < 94) kind = CH_LONE_HIGH;
			else                kind = CH_JUNK;
			case (kind)
				CH_ASCII: add_byte(8'($urandom_range(127)));
				CH_TWO:   push_form2(11'($urandom_range(11'h7FF)));
				CH_THREE: begin
					v = 16'($urandom_range(16'hFFFF));
					if (v >= HIGH_SURR_MIN && v <= HIGH_SURR_MAX) v = v ^ 16'h4000;
					push_form3(v);
				end
				CH_PAIR: begin
					supp = 20'($urandom_range(20'hFFFFF));
					push_form3(HIGH_SURR_MIN | {6'h00, supp[19:10]});
					push_form3(16'hDC00 | {6'h00, supp[9:0]});
				end
				CH_LONE_LOW:  push_form3(16'hDC00 | 16'($urandom_range(10'h3FF)));
				CH_LONE_HIGH: push_form3(HIGH_SURR_MIN | 16'($urandom_range(10'h3FF)));
				default:      add_byte(8'($urandom_range(255)));
			endcase
		end
		pick = $urandom_range(99);
		if (pick < 8) begin
			string_bytes[$urandom_range(string_bytes.size() - 1)] = 8'($urandom_range(255));
		end else if (pick < 15) begin
			cut = $urandom_range(2, 1);
			while (cut > 0 && string_bytes.size() > 1) begin
				void'(string_bytes.pop_back());
				cut--;
			end
		end
	endfunction

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (code_points_due.size() == 0) begin
				report_mismatch("unexpected result", 32'h0,
					32'({m_tuser, m_tlast, m_tdata}));
			end else begin
				want = code_points_due.pop_front();
				if (m_tdata !== {3'b000, want.code_point})
					report_mismatch("code_point", 32'(want.code_point), 32'(m_tdata));
				if (m_tuser !== want.decode_error)
					report_mismatch("decode_error", 32'(want.decode_error), 32'(m_tuser));
				if (m_tlast !== want.string_end)
					report_mismatch("string_end", 32'(want.string_end), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = directed_rows[i];
			send_byte(row.b, row.last, row.typed,
				'{code_point: row.cp, decode_error: row.err, string_end: row.last});
		end

		while (live_bytes < RANDOM_BYTES + NUM_ROWS) begin
			if (live_bytes < 600) begin
				send_idle = 12;
				recv_idle = 65;
			end else if (live_bytes < 1200) begin
				send_idle = 65;
				recv_idle = 12;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			build_string();
			for (int unsigned k = 0; k < string_bytes.size(); k++)
				send_byte(string_bytes[k], k == string_bytes.size() - 1, 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (code_points_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (code_points_due.size() != 0)
			report_mismatch("results never delivered", 32'h0,
				32'(code_points_due.size()));

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[modified_utf8_decoder.f]
rtl/mutf8_pkg.sv
rtl/modified_utf8_decoder.sv
sim/tb_modified_utf8_decoder.sv
